// File: design/pbd_pkg.sv
// shared types and constants for the packbits frame stream decoder
// no dependencies; used by every module of the block but pbd_ram
`timescale 1ns / 1ps

package pbd_pkg;

  // wire framing bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] FRAME_END   = 8'hBB;
  localparam logic [7:0] STOP_FIRST  = 8'hCC;
  localparam logic [7:0] STOP_SECOND = 8'hDD;

  // frame types
  localparam logic [7:0] KIND_RAW = 8'h00;
  localparam logic [7:0] KIND_XOR = 8'h02;

  // result event codes
  localparam logic [1:0] EV_FLUSH = 2'd0;
  localparam logic [1:0] EV_STOP  = 2'd1;
  localparam logic [1:0] EV_READ  = 2'd2;

  // command queue between parser and executor
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;
  localparam int CMD_CNT_W = 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR2,
    PH_TYPE,
    PH_LENHI,
    PH_LENLO,
    PH_DATA,
    PH_FLUSH,
    PH_STOP2
  } parse_phase_e;

  typedef enum logic [1:0] {
    UM_CTRL   = 2'd0,
    UM_LIT    = 2'd1,
    UM_RUN1   = 2'd2,
    UM_RUNREP = 2'd3
  } unpack_mode_e;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_PUT,
    CMD_UNPACK,
    CMD_FLUSH,
    CMD_STOP,
    CMD_READ
  } cmd_op_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PUT_RD,
    BK_PUT_WR,
    BK_READ,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  stream_byte;
    logic [12:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] frames_done;
    logic [12:0] bytes_decoded;
    logic [7:0]  frame_checksum;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  data;
    logic [12:0] addr;
  } cmd_t;

endpackage

// File: design/packbits_frame_stream_decoder.sv
// a stream beat is parsed in its accept cycle and queued; the executor takes a
// header or control byte in its idle state and makes each frame-store write as a
// read then a write (read-modify-write through the store's single read port), once
// per repeat of a run of up to 128 repeats
// throughput: one beat per cycle while the 4-entry command queue has room and the store clearing pass is over
// reset: a clearing pass writes white to all FRAME_BYTES store bytes, full stays high
`timescale 1ns / 1ps

// top level: queue-like in/out ports, parser front end, command queue and
// executor with the frame store
// depends on pbd_pkg, pbd_front, pbd_fifo and pbd_back
module packbits_frame_stream_decoder #(
  parameter int FRAME_BYTES = 4736
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beats
  input  logic               push,
  output logic               full,
  input  pbd_pkg::in_item_t  in_item_i,
  // result beats
  output logic               empty,
  input  logic               pop,
  output pbd_pkg::out_item_t out_item_o
);

  logic          cmd_full, cmd_empty, cmd_pop;
  logic          front_valid, clearing;
  logic          accept;
  pbd_pkg::cmd_t front_cmd, head_cmd;

  // the parser never blocks on its own, so the beat is taken whenever the
  // queue has room and the store clearing pass is over
  assign full   = cmd_full || clearing;
  assign accept = push && !full;

  // front: framing state and beat classification
  pbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .item_i     (in_item_i),
    .cmd_valid_o(front_valid),
    .cmd_o      (front_cmd)
  );

  // decoupling queue, keeps the parser running while the executor drains runs
  pbd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .cmd_i  (front_cmd),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .cmd_o  (head_cmd),
    .empty_o(cmd_empty)
  );

  // back: unpacking, store writes, checksum, reports
  pbd_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (cmd_pop),
    .clearing_o (clearing),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept)
    else $error("beat accepted during store clearing");
  a_queue_not_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_valid |-> !cmd_full)
    else $error("command pushed into full queue");
`endif

endmodule

// File: design/pbd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4736
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/pbd_fifo.sv
// short command queue between the stream parser and the executor
// depends on pbd_pkg
`timescale 1ns / 1ps

module pbd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbd_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output pbd_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  pbd_pkg::cmd_t                  mem_q [pbd_pkg::CMD_DEPTH];
  logic [pbd_pkg::CMD_PTR_W-1:0]  wr_q, wr_d;
  logic [pbd_pkg::CMD_PTR_W-1:0]  rd_q, rd_d;
  logic [pbd_pkg::CMD_CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == pbd_pkg::CMD_CNT_W'(pbd_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + pbd_pkg::CMD_CNT_W'(push_i) - pbd_pkg::CMD_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pbd_pkg::CMD_CNT_W'(pbd_pkg::CMD_DEPTH))
    else $error("command queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command popped from empty queue");
`endif

endmodule

// File: design/pbd_front.sv
// stream parser: tracks the frame header and turns header-end, payload, frame-end, stop and read beats into commands
// depends on pbd_pkg
`timescale 1ns / 1ps

module pbd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  pbd_pkg::in_item_t item_i,
  output logic              cmd_valid_o,
  output pbd_pkg::cmd_t     cmd_o
);

  pbd_pkg::parse_phase_e phase_q, phase_d;
  logic [7:0]            kind_q, kind_d;
  logic [15:0]           total_q, total_d;
  logic [15:0]           seen_q, seen_d;
  logic [7:0]            b;
  logic [15:0]           seen_inc;
  logic [15:0]           total_lo;

  assign b        = item_i.stream_byte;
  assign seen_inc = seen_q + 16'd1;
  assign total_lo = {total_q[15:8], b};

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (acc_i && !item_i.operation) begin
      case (phase_q)
        pbd_pkg::PH_IDLE: begin
          if (b == pbd_pkg::SYNC_FIRST) begin
            phase_d = pbd_pkg::PH_HDR2;
          end else if (b == pbd_pkg::STOP_FIRST) begin
            phase_d = pbd_pkg::PH_STOP2;
          end
        end
        pbd_pkg::PH_HDR2: begin
          phase_d = (b == pbd_pkg::SYNC_SECOND) ? pbd_pkg::PH_TYPE : pbd_pkg::PH_IDLE;
        end
        pbd_pkg::PH_TYPE:  phase_d = pbd_pkg::PH_LENHI;
        pbd_pkg::PH_LENHI: phase_d = pbd_pkg::PH_LENLO;
        pbd_pkg::PH_LENLO: begin
          phase_d = (total_lo != 16'd0) ? pbd_pkg::PH_DATA : pbd_pkg::PH_FLUSH;
        end
        pbd_pkg::PH_DATA: begin
          if (seen_inc >= total_q) begin
            phase_d = pbd_pkg::PH_FLUSH;
          end
        end
        default: phase_d = pbd_pkg::PH_IDLE;
      endcase
    end
  end

  // header fields and payload counter
  always_comb begin
    kind_d  = kind_q;
    total_d = total_q;
    seen_d  = seen_q;
    if (acc_i && !item_i.operation) begin
      case (phase_q)
        pbd_pkg::PH_TYPE:  kind_d = b;
        pbd_pkg::PH_LENHI: total_d = {b, 8'h00};
        pbd_pkg::PH_LENLO: begin
          total_d = total_lo;
          seen_d  = 16'd0;
        end
        pbd_pkg::PH_DATA:  seen_d = seen_inc;
        default: ;
      endcase
    end
  end

  // command out
  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_o.op    = pbd_pkg::CMD_READ;
    cmd_o.data  = b;
    cmd_o.addr  = 13'd0;
    if (acc_i) begin
      if (item_i.operation) begin
        cmd_valid_o = 1'b1;
        cmd_o.addr  = item_i.read_address;
      end else begin
        case (phase_q)
          pbd_pkg::PH_LENLO: begin
            cmd_valid_o = 1'b1;
            cmd_o.op    = pbd_pkg::CMD_START;
            cmd_o.data  = kind_q;
          end
          pbd_pkg::PH_DATA: begin
            cmd_valid_o = 1'b1;
            cmd_o.op    = (kind_q == pbd_pkg::KIND_RAW) ? pbd_pkg::CMD_PUT
                                                         : pbd_pkg::CMD_UNPACK;
          end
          pbd_pkg::PH_FLUSH: begin
            cmd_valid_o = (b == pbd_pkg::FRAME_END);
            cmd_o.op    = pbd_pkg::CMD_FLUSH;
          end
          pbd_pkg::PH_STOP2: begin
            cmd_valid_o = (b == pbd_pkg::STOP_SECOND);
            cmd_o.op    = pbd_pkg::CMD_STOP;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pbd_pkg::PH_IDLE;
      kind_q  <= 8'h00;
      total_q <= 16'd0;
      seen_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      total_q <= total_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// File: design/pbd_back.sv
// executor: runs queued commands against the frame store, unpacks runs,
// keeps the checksum and frame counter, and holds the result register
// depends on pbd_pkg and pbd_ram
`timescale 1ns / 1ps

module pbd_back #(
  parameter int FRAME_BYTES = 4736
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  pbd_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               clearing_o,
  output logic               empty_o,
  input  logic               pop_i,
  output pbd_pkg::out_item_t out_item_o
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int WW = $clog2(FRAME_BYTES + 1);
  localparam int XW = (AW > 13) ? AW : 13;
  localparam logic [WW-1:0] FbW     = WW'(FRAME_BYTES);
  localparam logic [AW-1:0] ClrLast = AW'(FRAME_BYTES - 1);
  localparam logic [XW-1:0] FbX     = XW'(FRAME_BYTES);

  pbd_pkg::back_state_e  state_q, state_d, fin_next;
  pbd_pkg::unpack_mode_e mode_q, mode_d, cur_mode, head_mode;
  pbd_pkg::cmd_t         cur_q, cur_d;
  pbd_pkg::out_item_t    out_q, out_d, result;
  logic [AW-1:0]         clr_q, clr_d;
  logic [7:0]            kind_q, kind_d;
  logic [WW-1:0]         wi_q, wi_d, wi_fin;
  logic [7:0]            cnt_q, cnt_d, cnt_dec, cur_cnt, head_cnt;
  logic [7:0]            rep_q, rep_d;
  logic [7:0]            xor_q, xor_d;
  logic [15:0]           fc_q, fc_d;
  logic [7:0]            rd_q, rd_d;
  logic                  out_valid_q, out_valid_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [7:0]            ram_wdata, ram_rdata;

  logic                  wi_ok, finish, cnt_zero, out_room, out_load, head_in_range;
  logic [7:0]            put_val, new_val;

  pbd_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign wi_ok    = (wi_q < FbW);
  assign finish   = ((state_q == pbd_pkg::BK_PUT_RD) && !wi_ok) ||
                    (state_q == pbd_pkg::BK_PUT_WR);
  assign wi_fin   = (state_q == pbd_pkg::BK_PUT_WR) ? wi_q + 1'b1 : wi_q;
  assign cnt_dec  = cnt_q - 8'd1;
  assign cnt_zero = (cnt_dec == 8'd0);
  assign out_room = !out_valid_q || pop_i;
  assign put_val  = (mode_q == pbd_pkg::UM_RUNREP) ? rep_q : cur_q.data;
  assign new_val  = (kind_q == pbd_pkg::KIND_XOR) ? (ram_rdata ^ put_val) : put_val;

  // control byte: repeat or literal count is the low seven bits plus one
  assign head_cnt  = {1'b0, cmd_i.data[6:0]} + 8'd1;
  assign head_mode = cmd_i.data[7] ? pbd_pkg::UM_RUN1 : pbd_pkg::UM_LIT;
  assign cur_cnt   = {1'b0, cur_q.data[6:0]} + 8'd1;
  assign cur_mode  = cur_q.data[7] ? pbd_pkg::UM_RUN1 : pbd_pkg::UM_LIT;

  assign head_in_range = (XW'(cmd_i.addr) < FbX);

  // where to go once a store write (or a dropped one) completes
  always_comb begin
    case (cur_q.op)
      pbd_pkg::CMD_UNPACK: begin
        fin_next = ((mode_q == pbd_pkg::UM_RUNREP) && !cnt_zero) ? pbd_pkg::BK_PUT_RD
                                                                  : pbd_pkg::BK_IDLE;
      end
      pbd_pkg::CMD_FLUSH: begin
        fin_next = (cnt_zero || !(wi_fin < FbW)) ? pbd_pkg::BK_EMIT : pbd_pkg::BK_PUT_RD;
      end
      default: fin_next = pbd_pkg::BK_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbd_pkg::BK_CLEAR: begin
        if (clr_q == ClrLast) begin
          state_d = pbd_pkg::BK_IDLE;
        end
      end
      pbd_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            pbd_pkg::CMD_PUT: state_d = pbd_pkg::BK_PUT_RD;
            pbd_pkg::CMD_UNPACK: begin
              if (mode_q != pbd_pkg::UM_CTRL) begin
                state_d = pbd_pkg::BK_PUT_RD;
              end
            end
            pbd_pkg::CMD_FLUSH: begin
              state_d = ((kind_q != pbd_pkg::KIND_RAW) && (mode_q == pbd_pkg::UM_RUNREP) &&
                         wi_ok) ? pbd_pkg::BK_PUT_RD : pbd_pkg::BK_EMIT;
            end
            pbd_pkg::CMD_STOP: state_d = pbd_pkg::BK_EMIT;
            pbd_pkg::CMD_READ: begin
              state_d = head_in_range ? pbd_pkg::BK_READ : pbd_pkg::BK_EMIT;
            end
            default: ;
          endcase
        end
      end
      pbd_pkg::BK_PUT_RD: state_d = wi_ok ? pbd_pkg::BK_PUT_WR : fin_next;
      pbd_pkg::BK_PUT_WR: state_d = fin_next;
      pbd_pkg::BK_READ:   state_d = pbd_pkg::BK_EMIT;
      pbd_pkg::BK_EMIT: begin
        if (out_room) begin
          state_d = pbd_pkg::BK_IDLE;
        end
      end
      default: state_d = pbd_pkg::BK_IDLE;
    endcase
  end

  // result for the command being reported
  always_comb begin
    result = '0;
    case (cur_q.op)
      pbd_pkg::CMD_FLUSH: begin
        result.event_kind     = pbd_pkg::EV_FLUSH;
        result.frames_done    = fc_q + 16'd1;
        result.bytes_decoded  = 13'(wi_q);
        result.frame_checksum = xor_q;
      end
      pbd_pkg::CMD_STOP: result.event_kind = pbd_pkg::EV_STOP;
      default: begin
        result.event_kind = pbd_pkg::EV_READ;
        result.read_data  = rd_q;
      end
    endcase
  end

  // datapath and store access
  always_comb begin
    clr_d     = clr_q;
    cur_d     = cur_q;
    kind_d    = kind_q;
    wi_d      = wi_q;
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    rep_d     = rep_q;
    xor_d     = xor_q;
    fc_d      = fc_q;
    rd_d      = rd_q;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(wi_q);
    ram_wdata = new_val;
    ram_re    = 1'b0;
    ram_raddr = AW'(wi_q);

    case (state_q)
      pbd_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'hFF;
        clr_d     = clr_q + 1'b1;
      end
      pbd_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          case (cmd_i.op)
            pbd_pkg::CMD_START: begin
              kind_d = cmd_i.data;
              wi_d   = '0;
              mode_d = pbd_pkg::UM_CTRL;
              cnt_d  = 8'd0;
              rep_d  = 8'd0;
            end
            pbd_pkg::CMD_UNPACK: begin
              if (mode_q == pbd_pkg::UM_CTRL) begin
                cnt_d  = head_cnt;
                mode_d = head_mode;
              end
            end
            pbd_pkg::CMD_READ: begin
              if (head_in_range) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cmd_i.addr);
              end else begin
                rd_d = 8'h00;
              end
            end
            default: ;
          endcase
        end
      end
      pbd_pkg::BK_PUT_RD: begin
        ram_re = wi_ok;
      end
      pbd_pkg::BK_PUT_WR: begin
        // checksum tracks the store: swap the old byte for the new one
        ram_we = 1'b1;
        xor_d  = xor_q ^ ram_rdata ^ new_val;
        wi_d   = wi_q + 1'b1;
      end
      pbd_pkg::BK_READ: begin
        rd_d = ram_rdata;
      end
      pbd_pkg::BK_EMIT: begin
        if (out_room) begin
          out_load = 1'b1;
          if (cur_q.op == pbd_pkg::CMD_FLUSH) begin
            fc_d = fc_q + 16'd1;
          end else if (cur_q.op == pbd_pkg::CMD_STOP) begin
            fc_d = 16'd0;
          end
        end
      end
      default: ;
    endcase

    // run bookkeeping after each store write or dropped write
    if (finish) begin
      case (cur_q.op)
        pbd_pkg::CMD_UNPACK: begin
          case (mode_q)
            pbd_pkg::UM_RUNREP: begin
              cnt_d = cnt_dec;
              if (cnt_zero) begin
                // run drained, the pending byte is a control byte
                cnt_d  = cur_cnt;
                mode_d = cur_mode;
              end
            end
            pbd_pkg::UM_LIT: begin
              cnt_d = cnt_dec;
              if (cnt_zero) begin
                mode_d = pbd_pkg::UM_CTRL;
              end
            end
            default: begin
              rep_d  = cur_q.data;
              cnt_d  = cnt_dec;
              mode_d = cnt_zero ? pbd_pkg::UM_CTRL : pbd_pkg::UM_RUNREP;
            end
          endcase
        end
        pbd_pkg::CMD_FLUSH: begin
          cnt_d = cnt_dec;
          if (cnt_zero) begin
            mode_d = pbd_pkg::UM_CTRL;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end
  end

  assign clearing_o = (state_q == pbd_pkg::BK_CLEAR);
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbd_pkg::BK_CLEAR;
      clr_q       <= '0;
      kind_q      <= 8'h00;
      wi_q        <= '0;
      mode_q      <= pbd_pkg::UM_CTRL;
      cnt_q       <= 8'd0;
      rep_q       <= 8'd0;
      xor_q       <= FRAME_BYTES[0] ? 8'hFF : 8'h00;
      fc_q        <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      kind_q      <= kind_d;
      wi_q        <= wi_d;
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      rep_q       <= rep_d;
      xor_q       <= xor_d;
      fc_q        <= fc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rd_q  <= rd_d;
    out_q <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> pop_i)
    else $error("result register overwritten before it was taken");
  a_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_q <= FbW)
    else $error("write index past frame end");
  a_run_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == pbd_pkg::UM_RUNREP) |-> (cnt_q != 8'd0))
    else $error("repeat run pending with zero count");
  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == pbd_pkg::BK_IDLE))
    else $error("command taken while executor busy");
`endif

endmodule
